// ----- hdl/pld_pkg.sv -----
`timescale 1ns / 1ps
package pld_pkg;

  // fixed number formats
  localparam int CoordW = 32;
  localparam int AccW   = 48;
  localparam int DiffW  = CoordW + 1;       // point or rate difference
  localparam int ProdW  = 2 * DiffW;        // one signed product
  localparam int SqW    = 2 * CoordW + 2;   // sum of three squares
  localparam int DotW   = 2 * CoordW + 3;   // signed dot product
  localparam int NumW   = 2 * CoordW + 2;   // dot product magnitude
  localparam int LenW   = CoordW + 1;       // segment length
  localparam int CntW   = $clog2(NumW + 1);

  typedef struct packed {
    logic signed [CoordW-1:0] point_x;
    logic signed [CoordW-1:0] point_y;
    logic signed [CoordW-1:0] point_z;
    logic signed [CoordW-1:0] rate_x;
    logic signed [CoordW-1:0] rate_y;
    logic signed [CoordW-1:0] rate_z;
    logic                     last_point;
  } in_item_t;

  typedef struct packed {
    logic        [AccW-2:0] total_length;
    logic signed [AccW-1:0] length_rate;
    logic                   zero_segment_seen;
    logic                   saturated;
  } out_item_t;

  // one classified item between front and back
  typedef struct packed {
    logic signed [DiffW-1:0] dx;
    logic signed [DiffW-1:0] dy;
    logic signed [DiffW-1:0] dz;
    logic signed [DiffW-1:0] ex;
    logic signed [DiffW-1:0] ey;
    logic signed [DiffW-1:0] ez;
    logic                    has_seg;
    logic                    last;
  } seg_t;

endpackage

// ----- hdl/polyline_length_with_derivative.sv -----
`timescale 1ns / 1ps
// channel  | valid         | stall         | payload
// input    | point_valid   | point_stall   | point  (pld_pkg::in_item_t)
// output   | result_valid  | result_stall  | result (pld_pkg::out_item_t)
//
// a point after the first of its polyline passes through the back part in steps:
// the shared multiplier, the bit-serial root and the bit-serial divider, plus
// control states; a first point skips them
// the front takes items into a two-entry queue, so up to two items wait there
// rst is synchronous and active high and clears all control and accumulators
// a stalled result holds in the output register; the back part waits only
// when a second report meets a full output register
module polyline_length_with_derivative (
  input  logic                clk,
  input  logic                rst,
  input  logic                point_valid,
  output logic                point_stall,
  input  pld_pkg::in_item_t   point,
  output logic                result_valid,
  input  logic                result_stall,
  output pld_pkg::out_item_t  result
);
  import pld_pkg::*;

  logic q_push, q_full, q_pop, q_empty;
  seg_t q_wr, q_rd;

  pld_front u_front (
    .clk         (clk),
    .rst         (rst),
    .point_valid (point_valid),
    .point_stall (point_stall),
    .point       (point),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (q_wr)
  );

  pld_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_data (q_wr),
    .full    (q_full),
    .pop     (q_pop),
    .empty   (q_empty),
    .rd_data (q_rd)
  );

  pld_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_data       (q_rd),
    .q_pop        (q_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );
endmodule

// ----- hdl/pld_front.sv -----
`timescale 1ns / 1ps
module pld_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             point_valid,
  output logic             point_stall,
  input  pld_pkg::in_item_t point,
  input  logic             q_full,
  output logic             q_push,
  output pld_pkg::seg_t    q_data
);
  import pld_pkg::*;

  logic signed [CoordW-1:0] prev_px, prev_py, prev_pz, prev_rx, prev_ry, prev_rz;
  logic                     have_prev;

  function automatic logic signed [DiffW-1:0] sub(input logic signed [CoordW-1:0] a,
                                                  input logic signed [CoordW-1:0] b);
    sub = DiffW'(a) - DiffW'(b);
  endfunction

  assign point_stall = q_full;
  assign q_push      = point_valid && !q_full;

  // differences against the stored point
  always_comb begin
    q_data.dx      = sub(point.point_x, prev_px);
    q_data.dy      = sub(point.point_y, prev_py);
    q_data.dz      = sub(point.point_z, prev_pz);
    q_data.ex      = sub(point.rate_x, prev_rx);
    q_data.ey      = sub(point.rate_y, prev_ry);
    q_data.ez      = sub(point.rate_z, prev_rz);
    q_data.has_seg = have_prev;
    q_data.last    = point.last_point;
  end

  // previous point store
  always_ff @(posedge clk) begin
    if (rst) begin
      have_prev <= 1'b0;
      prev_px   <= '0;
      prev_py   <= '0;
      prev_pz   <= '0;
      prev_rx   <= '0;
      prev_ry   <= '0;
      prev_rz   <= '0;
    end else if (q_push) begin
      have_prev <= !point.last_point;
      prev_px   <= point.point_x;
      prev_py   <= point.point_y;
      prev_pz   <= point.point_z;
      prev_rx   <= point.rate_x;
      prev_ry   <= point.rate_y;
      prev_rz   <= point.rate_z;
    end
  end
endmodule

// ----- hdl/pld_queue.sv -----
`timescale 1ns / 1ps
module pld_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  pld_pkg::seg_t wr_data,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output pld_pkg::seg_t rd_data
);
  import pld_pkg::*;

  seg_t       entry [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign rd_data = entry[rd_ptr];

  // two-entry ring
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= wr_data;
    end
  end
endmodule

// ----- hdl/pld_back.sv -----
`timescale 1ns / 1ps
module pld_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  input  pld_pkg::seg_t      q_data,
  output logic               q_pop,
  output logic               result_valid,
  input  logic               result_stall,
  output pld_pkg::out_item_t result
);
  import pld_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_SQRT = 3'd2;
  localparam logic [2:0] S_LEN  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_ACC  = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  localparam logic [AccW-1:0]   LenMax = {1'b0, {(AccW-1){1'b1}}};
  localparam logic [AccW:0]     QCap   = {1'b1, {AccW{1'b0}}};
  localparam logic signed [AccW+1:0] RMax = (AccW+2)'({(AccW-1){1'b1}});
  localparam logic signed [AccW+1:0] RMin = -RMax - (AccW+2)'(1);

  logic [2:0]               state;
  logic [2:0]               step;
  logic [CntW-1:0]          cnt;
  seg_t                     cur;
  logic signed [ProdW-1:0]  prod;
  logic [SqW-1:0]           sq;
  logic signed [DotW-1:0]   dot;
  logic [LenW+2:0]          srem;
  logic [LenW-1:0]          root;
  logic [NumW-1:0]          num;
  logic [NumW-1:0]          quo;
  logic [LenW-1:0]          drem;
  logic                     neg;
  logic [AccW-2:0]          length_sum;
  logic signed [AccW-1:0]   rate_sum;
  logic                     zero_flag, sat_flag;

  logic signed [DiffW-1:0]  mul_a, mul_b;
  logic [LenW+2:0]          srem_try, strial;
  logic [LenW:0]            dtry;
  logic [AccW-1:0]          len_add;
  logic [AccW:0]            qc;
  logic signed [AccW+1:0]   term, rate_new;
  logic signed [DotW-1:0]   dot_abs;

  // operand select for the shared multiplier
  always_comb begin
    case (step)
      3'd0:    begin mul_a = cur.dx; mul_b = cur.dx; end
      3'd1:    begin mul_a = cur.dy; mul_b = cur.dy; end
      3'd2:    begin mul_a = cur.dz; mul_b = cur.dz; end
      3'd3:    begin mul_a = cur.dx; mul_b = cur.ex; end
      3'd4:    begin mul_a = cur.dy; mul_b = cur.ey; end
      default: begin mul_a = cur.dz; mul_b = cur.ez; end
    endcase
  end

  // one root bit, one quotient bit, and the accumulator updates
  always_comb begin
    srem_try = {srem[LenW:0], sq[SqW-1 -: 2]};
    strial   = (LenW+3)'({root, 2'b01});
    dtry     = {drem, num[NumW-1]};
    len_add  = AccW'(length_sum) + AccW'(root);
    qc       = (quo > NumW'(QCap)) ? QCap : quo[AccW:0];
    term     = neg ? -$signed({1'b0, qc}) : $signed({1'b0, qc});
    rate_new = (AccW+2)'(rate_sum) + term;
    dot_abs  = dot[DotW-1] ? -dot : dot;
  end

  assign q_pop = (state == S_IDLE) && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      step         <= '0;
      cnt          <= '0;
      length_sum   <= '0;
      rate_sum     <= '0;
      zero_flag    <= 1'b0;
      sat_flag     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall && !(state == S_FIN && cur.last)) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (!q_empty) begin
            cur   <= q_data;
            step  <= '0;
            sq    <= '0;
            dot   <= '0;
            state <= q_data.has_seg ? S_MUL : S_FIN;
          end
        end
        // six products, each accumulated in the cycle after it is registered
        S_MUL: begin
          prod <= mul_a * mul_b;
          if (step != 3'd0) begin
            if (step <= 3'd3) begin
              sq <= sq + SqW'($unsigned(prod));
            end else begin
              dot <= dot + DotW'(prod);
            end
          end
          step <= step + 3'd1;
          if (step == 3'd6) begin
            srem  <= '0;
            root  <= '0;
            cnt   <= CntW'(LenW - 1);
            state <= S_SQRT;
          end
        end
        // restoring square root, one bit a cycle
        S_SQRT: begin
          sq <= sq << 2;
          if (srem_try >= strial) begin
            srem <= srem_try - strial;
            root <= {root[LenW-2:0], 1'b1};
          end else begin
            srem <= srem_try;
            root <= {root[LenW-2:0], 1'b0};
          end
          cnt <= cnt - CntW'(1);
          if (cnt == '0) begin
            state <= S_LEN;
          end
        end
        // length accumulate and zero segment check
        S_LEN: begin
          if (len_add > LenMax) begin
            length_sum <= LenMax[AccW-2:0];
            sat_flag   <= 1'b1;
          end else begin
            length_sum <= len_add[AccW-2:0];
          end
          neg  <= dot[DotW-1];
          num  <= dot_abs[NumW-1:0];
          quo  <= '0;
          drem <= '0;
          cnt  <= CntW'(NumW - 1);
          if (root == '0) begin
            zero_flag <= 1'b1;
            state     <= S_FIN;
          end else begin
            state <= S_DIV;
          end
        end
        // restoring divide by the length, one bit a cycle
        S_DIV: begin
          num <= num << 1;
          if (dtry >= {1'b0, root}) begin
            drem <= LenW'(dtry - {1'b0, root});
            quo  <= {quo[NumW-2:0], 1'b1};
          end else begin
            drem <= dtry[LenW-1:0];
            quo  <= {quo[NumW-2:0], 1'b0};
          end
          cnt <= cnt - CntW'(1);
          if (cnt == '0) begin
            state <= S_ACC;
          end
        end
        // saturating rate accumulate
        S_ACC: begin
          if (rate_new > RMax) begin
            rate_sum <= RMax[AccW-1:0];
            sat_flag <= 1'b1;
          end else if (rate_new < RMin) begin
            rate_sum <= RMin[AccW-1:0];
            sat_flag <= 1'b1;
          end else begin
            rate_sum <= rate_new[AccW-1:0];
          end
          state <= S_FIN;
        end
        // report on the last point once the output register is free
        S_FIN: begin
          if (!cur.last) begin
            state <= S_IDLE;
          end else if (!result_valid || !result_stall) begin
            result.total_length      <= length_sum;
            result.length_rate       <= rate_sum;
            result.zero_segment_seen <= zero_flag;
            result.saturated         <= sat_flag;
            result_valid             <= 1'b1;
            length_sum               <= '0;
            rate_sum                 <= '0;
            zero_flag                <= 1'b0;
            sat_flag                 <= 1'b0;
            state                    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end
endmodule

// ----- tb/polyline_length_with_derivative_test.sv -----
`timescale 1ns / 1ps
module polyline_length_with_derivative_test;
  import pld_pkg::*;

  localparam longint LenMax  = (64'sd1 <<< (AccW - 1)) - 1;
  localparam longint RateMax = (64'sd1 <<< (AccW - 1)) - 1;
  localparam longint RateMin = -(64'sd1 <<< (AccW - 1));
  localparam int     LongPoints = 30;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       point_valid = 1'b0;
  logic       point_stall;
  in_item_t   point = '0;
  logic       result_valid;
  logic       result_stall = 1'b0;
  out_item_t  result;

  polyline_length_with_derivative uut (
    .clk(clk), .rst(rst),
    .point_valid(point_valid), .point_stall(point_stall), .point(point),
    .result_valid(result_valid), .result_stall(result_stall), .result(result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state for the polyline in progress
  longint    prev_pt [3];
  longint    prev_rt [3];
  bit        have_prev;
  longint    len_acc;
  longint    rate_acc;
  bit        zero_flag;
  bit        sat_flag;

  in_item_t  pending_points[$];
  out_item_t expected_reports[$];
  int        errors = 0;
  int        points_sent = 0;
  int        reports_seen = 0;

  // add one segment to the running length and derivative
  task automatic add_segment(input longint p [3], input longint r [3]);
    logic signed [127:0] dw, ew, dot, mag;
    logic [127:0] sq, root, trial, quot;
    longint term;
    sq = '0;
    dot = '0;
    for (int i = 0; i < 3; i++) begin
      dw = p[i] - prev_pt[i];
      ew = r[i] - prev_rt[i];
      sq = sq + dw * dw;
      dot = dot + dw * ew;
    end
    root = '0;
    for (int b = 40; b >= 0; b--) begin
      trial = root | (128'd1 << b);
      if (trial * trial <= sq) root = trial;
    end
    if (longint'(root) > LenMax - len_acc) begin
      len_acc = LenMax;
      sat_flag = 1'b1;
    end else begin
      len_acc = len_acc + longint'(root);
    end
    if (root == 0) begin
      zero_flag = 1'b1;
    end else begin
      mag = (dot < 0) ? -dot : dot;
      quot = mag / root;
      if (quot > 128'h7fff_ffff_ffff_ffff) quot = 128'h7fff_ffff_ffff_ffff;
      term = (dot < 0) ? -longint'(quot) : longint'(quot);
      if (term > 0 && rate_acc > RateMax - term) begin
        rate_acc = RateMax;
        sat_flag = 1'b1;
      end else if (term < 0 && rate_acc < RateMin - term) begin
        rate_acc = RateMin;
        sat_flag = 1'b1;
      end else begin
        rate_acc = rate_acc + term;
      end
    end
  endtask

  // take one accepted point; queue a report on the last one
  task automatic take_point(input in_item_t it);
    longint p [3];
    longint r [3];
    out_item_t rep;
    p = '{longint'(it.point_x), longint'(it.point_y), longint'(it.point_z)};
    r = '{longint'(it.rate_x), longint'(it.rate_y), longint'(it.rate_z)};
    if (have_prev) add_segment(p, r);
    prev_pt = p;
    prev_rt = r;
    have_prev = 1'b1;
    if (it.last_point) begin
      rep.total_length = len_acc[AccW-2:0];
      rep.length_rate = rate_acc[AccW-1:0];
      rep.zero_segment_seen = zero_flag;
      rep.saturated = sat_flag;
      expected_reports.push_back(rep);
      have_prev = 1'b0;
      len_acc = 0;
      rate_acc = 0;
      zero_flag = 1'b0;
      sat_flag = 1'b0;
    end
  endtask

  function automatic in_item_t make_point(input logic [31:0] px, py, pz, rx, ry, rz,
                                          input bit last);
    make_point = '{px, py, pz, rx, ry, rz, last};
  endfunction

  // coordinate of random size: full range, modest, tiny, or a random low half
  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: rand_coord = $urandom;
      1: rand_coord = 32'($signed($urandom_range(0, 2000000)) - 1000000);
      2: rand_coord = 32'($signed($urandom_range(0, 64)) - 32);
      default: rand_coord = {$urandom_range(0, 1) ? 16'hffff : 16'h0, 16'($urandom)};
    endcase
  endfunction

  // sender: bursts of random length with gaps between
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      point_valid <= 1'b0;
    end else if (!point_valid || !point_stall) begin
      if (point_valid) begin
        take_point(point);
        points_sent++;
      end
      if (gap_left > 0) begin
        gap_left--;
        point_valid <= 1'b0;
      end else if (pending_points.size() > 0) begin
        point <= pending_points.pop_front();
        point_valid <= 1'b1;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 150);
        end else begin
          burst_left--;
        end
      end else begin
        point_valid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern of busy and free stretches, each chosen at random
  int stall_phase = 0;
  bit stall_busy = 1'b0;
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (stall_phase == 0) begin
        stall_phase = $urandom_range(50, 800);
        stall_busy = $urandom_range(0, 1);
      end else begin
        stall_phase--;
      end
      result_stall <= stall_busy && ($urandom_range(0, 3) != 0);
    end
  end

  // check each accepted report against the oldest prediction
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && result_valid && !result_stall) begin
      reports_seen++;
      if (expected_reports.size() == 0) begin
        $error("report with none expected: length %0d", result.total_length);
        errors++;
      end else begin
        want = expected_reports.pop_front();
        if (result.total_length !== want.total_length) begin
          $error("total_length expected %0d got %0d", want.total_length,
                 result.total_length);
          errors++;
        end
        if (result.length_rate !== want.length_rate) begin
          $error("length_rate expected %0d got %0d", want.length_rate,
                 result.length_rate);
          errors++;
        end
        if (result.zero_segment_seen !== want.zero_segment_seen) begin
          $error("zero_segment_seen expected %0b got %0b", want.zero_segment_seen,
                 result.zero_segment_seen);
          errors++;
        end
        if (result.saturated !== want.saturated) begin
          $error("saturated expected %0b got %0b", want.saturated, result.saturated);
          errors++;
        end
      end
    end
  end

  // stimulus and end of run
  initial begin
    int n;
    logic [31:0] s;
    have_prev = 1'b0;
    len_acc = 0;
    rate_acc = 0;
    zero_flag = 1'b0;
    sat_flag = 1'b0;
    prev_pt = '{0, 0, 0};
    prev_rt = '{0, 0, 0};

    // single-point polyline
    pending_points.push_back(make_point(32'h7fffffff, 32'h80000000, 0, 5, 6, 7, 1'b1));
    // extreme jump on every axis with extreme rates
    pending_points.push_back(make_point(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                                        32'h80000000, 32'h7fffffff, 32'h80000000, 1'b0));
    pending_points.push_back(make_point(32'h80000000, 32'h80000000, 32'h80000000,
                                        32'h7fffffff, 32'h80000000, 32'h7fffffff, 1'b1));
    // repeated point gives a zero-length segment, then a normal one
    pending_points.push_back(make_point(32'h10000, 32'h20000, 32'h30000, 1, 2, 3, 1'b0));
    pending_points.push_back(make_point(32'h10000, 32'h20000, 32'h30000, 9, 9, 9, 1'b0));
    pending_points.push_back(make_point(32'h40000, 32'h60000, 32'h30000,
                                        32'hfff00000, 4, 32'h7fffffff, 1'b1));
    // only zero segments
    pending_points.push_back(make_point(0, 0, 0, 0, 0, 0, 1'b0));
    pending_points.push_back(make_point(0, 0, 0, 32'hffffffff, 0, 0, 1'b1));
    // one-lsb steps, positive and negative rates
    pending_points.push_back(make_point(0, 0, 0, 0, 0, 0, 1'b0));
    pending_points.push_back(make_point(1, 0, 0, 32'hffffffff, 0, 0, 1'b0));
    pending_points.push_back(make_point(1, 1, 0, 0, 1, 0, 1'b0));
    pending_points.push_back(make_point(1, 1, 32'hffffffff, 0, 0, 32'h7fffffff, 1'b1));

    // random polylines, mostly short
    n = 0;
    while (n < 360) begin
      int len;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
      for (int k = 0; k < len; k++) begin
        if (k > 0 && $urandom_range(0, 15) == 0) begin
          in_item_t dup;
          dup = pending_points[pending_points.size() - 1];
          dup.rate_x = rand_coord();
          dup.last_point = (k == len - 1);
          pending_points.push_back(dup);
        end else begin
          pending_points.push_back(make_point(rand_coord(), rand_coord(), rand_coord(),
                                              rand_coord(), rand_coord(), rand_coord(),
                                              k == len - 1));
        end
        n++;
      end
    end

    // one longer polyline of extreme jumps builds up large totals
    for (int k = 0; k < LongPoints; k++) begin
      s = k[0] ? 32'h80000000 : 32'h7fffffff;
      pending_points.push_back(make_point(s, s, s, s, s, s, k == LongPoints - 1));
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (pending_points.size() > 0 || point_valid) @(posedge clk);
    while (expected_reports.size() > 0) @(posedge clk);
    repeat (400) @(posedge clk);

    $display("%0d points in, %0d reports checked, including zero segments,",
             points_sent, reports_seen);
    $display("single points, extreme jumps and a long polyline of extreme jumps");
    if (errors == 0 && expected_reports.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #80ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ----- files.f -----
hdl/pld_pkg.sv
hdl/pld_front.sv
hdl/pld_queue.sv
hdl/pld_back.sv
hdl/polyline_length_with_derivative.sv
tb/polyline_length_with_derivative_test.sv
